/* rtl/core/stq_pkg.sv */
// stq_pkg: shared sizes, codes and beat types of the sorted timer queue
// depends on nothing; imported by stq_cell and sorted_timer_queue

package stq_pkg;

    localparam int MAX_TIMERS = 16;
    localparam int RESULT_CAP = 16;
    localparam int CAP_W      = (RESULT_CAP > 1) ? $clog2(RESULT_CAP) : 1;
    localparam int HANDLE_W   = 10;
    localparam int TIME_W     = 32;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_ADJUST = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ACK     = 2'd0,
        KIND_EXPIRED = 2'd1,
        KIND_NONE    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_DUPLICATE = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [HANDLE_W-1:0] handle;
        logic [TIME_W-1:0]   expire_time;
        logic [TIME_W-1:0]   now_time;
    } request_t;

    typedef struct packed {
        kind_t               kind;
        status_t             status;
        logic [HANDLE_W-1:0] out_handle;
        logic                last;
    } result_t;

    // what the whole row of cells does in one cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [TIME_W-1:0]   key_time;
        logic [HANDLE_W-1:0] key_handle;
    } cell_ctrl_t;

    typedef struct packed {
        logic                valid;
        logic [TIME_W-1:0]   expiry;
        logic [HANDLE_W-1:0] owner;
    } cell_data_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_EXEC,
        FSM_REINSERT,
        FSM_TICK
    } fsm_state_t;

endpackage

/* rtl/core/stq_cell.sv */
// stq_cell: one slot of the sorted chain, holding a timer and trading it with its neighbours
// depends on stq_pkg

module stq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  stq_pkg::cell_ctrl_t ctrl,
    input  stq_pkg::cell_data_t left,
    input  stq_pkg::cell_data_t right,
    input  logic               le_in,
    input  logic               shift_in,
    output stq_pkg::cell_data_t data,
    output logic               le_out,
    output logic               shift_out,
    output logic               match
);
    import stq_pkg::*;

    logic                valid_reg, valid_next;
    logic [TIME_W-1:0]   expiry_reg, expiry_next;
    logic [HANDLE_W-1:0] owner_reg, owner_next;
    logic                shift_here;

    assign le_out     = valid_reg && (expiry_reg <= ctrl.key_time);
    assign match      = valid_reg && (owner_reg == ctrl.key_handle);
    assign shift_here = shift_in || ((ctrl.op == CELL_DELETE) && match);
    assign shift_out  = shift_here;

    assign data.valid  = valid_reg;
    assign data.expiry = expiry_reg;
    assign data.owner  = owner_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        expiry_next = expiry_reg;
        owner_next  = owner_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                if (le_out)
                begin
                    // earlier or equal time stays put
                end
                else if (le_in)
                begin
                    valid_next  = 1'b1;
                    expiry_next = ctrl.key_time;
                    owner_next  = ctrl.key_handle;
                end
                else
                begin
                    valid_next  = left.valid;
                    expiry_next = left.expiry;
                    owner_next  = left.owner;
                end
            end
            CELL_DELETE, CELL_POP:
            begin
                if (shift_here)
                begin
                    valid_next  = right.valid;
                    expiry_next = right.expiry;
                    owner_next  = right.owner;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        expiry_reg <= expiry_next;
        owner_reg  <= owner_next;
    end

endmodule

/* rtl/core/sorted_timer_queue.sv */
// sorted_timer_queue: top level, command sequencer over a row of stq_cell slots
// depends on stq_pkg and stq_cell

// A command beat is taken when start is high and busy is low; busy then stays high
// until the cycle in which the command's last result appears, and is low in that cycle.
// Results appear on result for exactly one cycle each, marked by strobe, and cannot be
// held off. Add and delete latch the command, then let the cell row shift while the
// acknowledgement is registered; adjust first closes the gap in the row and then opens
// a new one. A tick returns one expired timer per result (at most RESULT_CAP), or a
// single empty result when none is due, because the row can pop only its front cell
// in a cycle. No clearing pass is needed after reset.

module sorted_timer_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  stq_pkg::request_t request,
    output logic              strobe,
    output stq_pkg::result_t  result
);
    import stq_pkg::*;

    fsm_state_t          state_reg, state_next;
    cmd_t                cmd_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [TIME_W-1:0]   key_reg;
    logic [CAP_W-1:0]    count_reg, count_next;
    logic                strobe_reg, strobe_next;
    result_t             result_reg, result_next;

    cell_ctrl_t          ctrl;
    cell_data_t          cell_q [MAX_TIMERS];
    logic [MAX_TIMERS-1:0] le;
    logic [MAX_TIMERS-1:0] shift;
    logic [MAX_TIMERS-1:0] match;
    logic [MAX_TIMERS-1:0] vmask;
    logic                accept;
    logic                found;
    logic                full;

    assign accept = start && (state_reg == FSM_IDLE);
    assign busy   = (state_reg != FSM_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    // any valid cell owning the handle; handles are unique in the row
    assign found = |match;
    assign full  = cell_q[MAX_TIMERS-1].valid;

    // the row of cells: each cell sees both neighbours, the ends see empty slots
    for (genvar i = 0; i < MAX_TIMERS; i++)
    begin : g_cell
        cell_data_t left_d, right_d;
        logic       le_left, shift_left;

        if (i == 0)
        begin : g_head
            assign left_d     = '0;
            assign le_left    = 1'b1;
            // a pop always shifts from the front
            assign shift_left = (ctrl.op == CELL_POP);
        end
        else
        begin : g_body
            assign left_d     = cell_q[i-1];
            assign le_left    = le[i-1];
            assign shift_left = shift[i-1];
        end

        if (i == MAX_TIMERS-1)
        begin : g_tail
            assign right_d = '0;
        end
        else
        begin : g_inner
            assign right_d = cell_q[i+1];
        end

        stq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .left      (left_d),
            .right     (right_d),
            .le_in     (le_left),
            .shift_in  (shift_left),
            .data      (cell_q[i]),
            .le_out    (le[i]),
            .shift_out (shift[i]),
            .match     (match[i])
        );

        assign vmask[i] = cell_q[i].valid;
    end

    // sequencer: one step of the cell row per cycle, result registered alongside
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;
        ctrl.op         = CELL_HOLD;
        ctrl.key_time   = key_reg;
        ctrl.key_handle = handle_reg;

        case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    state_next = (request.cmd == CMD_TICK) ? FSM_TICK : FSM_EXEC;
                    count_next = '0;
                end
            end

            FSM_EXEC:
            begin
                strobe_next            = 1'b1;
                result_next.kind       = KIND_ACK;
                result_next.status     = STAT_OK;
                result_next.out_handle = handle_reg;
                result_next.last       = 1'b1;
                state_next             = FSM_IDLE;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        // duplicate takes precedence over full
                        if (found)
                            result_next.status = STAT_DUPLICATE;
                        else if (full)
                            result_next.status = STAT_FULL;
                        else
                            ctrl.op = CELL_INSERT;
                    end
                    CMD_ADJUST:
                    begin
                        if (!found)
                        begin
                            result_next.status = STAT_NOT_FOUND;
                        end
                        else
                        begin
                            // take it out now, put it back next cycle; ack then
                            ctrl.op     = CELL_DELETE;
                            strobe_next = 1'b0;
                            state_next  = FSM_REINSERT;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (!found)
                            result_next.status = STAT_NOT_FOUND;
                        else
                            ctrl.op = CELL_DELETE;
                    end
                    default:
                    begin
                        strobe_next = 1'b0;
                    end
                endcase
            end

            FSM_REINSERT:
            begin
                ctrl.op                = CELL_INSERT;
                strobe_next            = 1'b1;
                result_next.kind       = KIND_ACK;
                result_next.status     = STAT_OK;
                result_next.out_handle = handle_reg;
                result_next.last       = 1'b1;
                state_next             = FSM_IDLE;
            end

            FSM_TICK:
            begin
                strobe_next        = 1'b1;
                result_next.status = STAT_OK;
                if (le[0])
                begin
                    // front timer is due: pop it, look at the next one for the last mark
                    ctrl.op                = CELL_POP;
                    result_next.kind       = KIND_EXPIRED;
                    result_next.out_handle = cell_q[0].owner;
                    result_next.last       = (count_reg == CAP_W'(RESULT_CAP - 1)) || !le[1];
                    count_next             = count_reg + 1'b1;
                    if (result_next.last)
                        state_next = FSM_IDLE;
                end
                else
                begin
                    // only reached with nothing due at the start of the tick
                    result_next.kind       = KIND_NONE;
                    result_next.out_handle = '0;
                    result_next.last       = 1'b1;
                    state_next             = FSM_IDLE;
                end
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FSM_IDLE;
            strobe_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            count_reg  <= count_next;
        end
    end

    // command latch and result payload carry no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= request.cmd;
            handle_reg <= request.handle;
            key_reg    <= (request.cmd == CMD_TICK) ? request.now_time : request.expire_time;
        end
        result_reg <= result_next;
    end

`ifndef SYNTHESIS
    // valid cells always form an unbroken run from the front
    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((vmask + 1'b1) & vmask) == '0)
        else $error("valid cells not contiguous");

    // a delete only happens when the handle is present, so the gap reaches the tail
    a_delete_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == CELL_DELETE) |-> shift[MAX_TIMERS-1])
        else $error("delete without a matching cell");

    // the final result of a command leaves the block idle in the same cycle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && result.last) |-> !busy)
        else $error("busy after last result");

    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !result.last) |-> busy)
        else $error("idle before last result");

    // acknowledgements and empty ticks are single beats
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (result.kind == KIND_ACK || result.kind == KIND_NONE)) |-> result.last)
        else $error("single-beat result without last mark");

    // an insert never runs on a full row
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == CELL_INSERT) |-> !full)
        else $error("insert into full row");
`endif

endmodule
